[rtl/core/etsm_pkg.sv]
// ---------------------------------------------------------------------------
// etsm_pkg: shared types and constants for the escape-time minimum unit
// Holds the fixed-point formats, register indexes, the controller state type
// and the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package etsm_pkg;

	localparam int FRAC_BITS = 28;
	localparam int ITER_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int STEP_W    = 31;
	localparam int OFFS_W    = 4;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_CAP = 3'd4;

	// Reset values of the configuration registers.
	localparam logic signed [COORD_W-1:0] CENTER_X_RST = -32'sd67108864;
	localparam logic signed [COORD_W-1:0] CENTER_Y_RST = 32'sd0;
	localparam logic [STEP_W-1:0]         STEP_X_RST   = 31'd134217728;
	localparam logic [STEP_W-1:0]         STEP_Y_RST   = 31'd134217728;
	localparam logic [ITER_BITS-1:0]      ITER_CAP_RST = 16'd1000;

	// An orbit escapes once |z|^2 exceeds 4, held at the product scale.
	localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

	localparam logic [ITER_BITS-1:0] ITER_ONES = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_MUL,
		ST_CHK,
		ST_FOLD
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic init;
		logic mul;
		logic chk;
		logic fold;
	} ctrl_cmd_t;

	typedef struct packed {
		logic finished;
		logic last;
		logic out_free;
	} dp_status_t;

	// Clamp a wide signed value to the signed coordinate range.
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
		lo = -hi - PROD_W'(1);
		if (v > hi) begin
			return hi[COORD_W-1:0];
		end else if (v < lo) begin
			return lo[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

endpackage

[rtl/core/etsm_ctrl.sv]
// ---------------------------------------------------------------------------
// etsm_ctrl: sequencer for the escape-time minimum unit
// Steps each item through coordinate setup, the square/update loop and the
// fold into the running minimum, and holds off input while busy.
// ---------------------------------------------------------------------------
module etsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  etsm_pkg::dp_status_t  status,
	output etsm_pkg::ctrl_cmd_t   cmd
);
	import etsm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_INIT;
				end
			end
			ST_INIT: state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_CHK;
			ST_CHK: begin
				state_nxt = status.finished ? ST_FOLD : ST_MUL;
			end
			ST_FOLD: begin
				// A batch end waits until the output register can take the item.
				if (!status.last || status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_INIT: cmd.init = 1'b1;
			ST_MUL:  cmd.mul  = 1'b1;
			ST_CHK:  cmd.chk  = 1'b1;
			ST_FOLD: cmd.fold = !status.last || status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/core/etsm_datapath.sv]
// ---------------------------------------------------------------------------
// etsm_datapath: arithmetic and storage of the escape-time minimum unit
// Configuration registers, sample coordinates, orbit registers with the
// square and cross products, the step counter, running minimum and output.
// ---------------------------------------------------------------------------
module etsm_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [etsm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [etsm_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic signed [etsm_pkg::OFFS_W-1:0]      col_offset,
	input  logic signed [etsm_pkg::OFFS_W-1:0]      row_offset,
	input  logic                                    last_sample,
	input  etsm_pkg::ctrl_cmd_t                     cmd,
	output etsm_pkg::dp_status_t                    status,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [etsm_pkg::ITER_BITS-1:0]          min_escape_iter
);
	import etsm_pkg::*;

	logic signed [COORD_W-1:0] center_x_q;
	logic signed [COORD_W-1:0] center_y_q;
	logic [STEP_W-1:0]         step_x_q;
	logic [STEP_W-1:0]         step_y_q;
	logic [ITER_BITS-1:0]      iter_cap_q;

	logic signed [OFFS_W-1:0]  col_q;
	logic signed [OFFS_W-1:0]  row_q;
	logic                      last_q;

	logic signed [COORD_W-1:0] cr_q;
	logic signed [COORD_W-1:0] ci_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic signed [PROD_W-1:0]  xx_q;
	logic signed [PROD_W-1:0]  yy_q;
	logic signed [PROD_W-1:0]  xy_q;
	logic                      first_q;
	logic [ITER_BITS-1:0]      count_q;
	logic [ITER_BITS-1:0]      run_min_q;
	logic [ITER_BITS-1:0]      out_q;
	logic                      out_valid_q;

	logic signed [PROD_W-1:0]  cx_wide;
	logic signed [PROD_W-1:0]  cy_wide;
	logic signed [PROD_W-1:0]  re_wide;
	logic signed [PROD_W-1:0]  im_wide;
	logic [PROD_W-1:0]         mag_sum;
	logic                      escaped;
	logic [ITER_BITS-1:0]      count_nxt;
	logic                      capped;
	logic [ITER_BITS-1:0]      min_nxt;
	logic                      out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			step_x_q   <= STEP_X_RST;
			step_y_q   <= STEP_Y_RST;
			iter_cap_q <= ITER_CAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CENTER_X: center_x_q <= cfg_data[COORD_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[COORD_W-1:0];
				REG_STEP_X:   step_x_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:   step_y_q   <= cfg_data[STEP_W-1:0];
				REG_ITER_CAP: iter_cap_q <= cfg_data[ITER_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sample point: centre plus offset times spacing, clamped to Q4.28.
	always_comb begin
		cx_wide = PROD_W'(center_x_q)
			+ PROD_W'(col_q) * PROD_W'($signed({1'b0, step_x_q}));
		cy_wide = PROD_W'(center_y_q)
			+ PROD_W'(row_q) * PROD_W'($signed({1'b0, step_y_q}));
	end

	// Next orbit point from the registered products; the shifts floor.
	always_comb begin
		re_wide = ((xx_q - yy_q) >>> FRAC_BITS) + PROD_W'(cr_q);
		im_wide = (xy_q >>> (FRAC_BITS - 1)) + PROD_W'(ci_q);
	end

	// The squares are never negative, so their sum fits unsigned.
	always_comb begin
		mag_sum   = $unsigned(xx_q) + $unsigned(yy_q);
		escaped   = !first_q && (mag_sum > ESC_LIMIT);
		count_nxt = count_q + ITER_BITS'(!first_q);
		capped    = count_nxt >= iter_cap_q;
		min_nxt   = (count_q < run_min_q) ? count_q : run_min_q;
		out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q  <= col_offset;
			row_q  <= row_offset;
			last_q <= last_sample;
		end
		if (cmd.init) begin
			cr_q    <= sat_coord(cx_wide);
			ci_q    <= sat_coord(cy_wide);
			x_q     <= sat_coord(cx_wide);
			y_q     <= sat_coord(cy_wide);
			count_q <= '0;
			first_q <= 1'b1;
		end
		if (cmd.mul) begin
			xx_q <= PROD_W'(x_q) * PROD_W'(x_q);
			yy_q <= PROD_W'(y_q) * PROD_W'(y_q);
			xy_q <= PROD_W'(x_q) * PROD_W'(y_q);
		end
		if (cmd.chk && !escaped) begin
			// An escaped point keeps its count; otherwise the step counts.
			count_q <= count_nxt;
			if (!capped) begin
				x_q     <= sat_coord(re_wide);
				y_q     <= sat_coord(im_wide);
				first_q <= 1'b0;
			end
		end
		if (cmd.fold && last_q) begin
			out_q <= (min_nxt == '0) ? ITER_BITS'(1) : min_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q   <= ITER_ONES;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fold) begin
				run_min_q <= last_q ? ITER_ONES : min_nxt;
			end
			if (cmd.fold && last_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.finished = escaped || capped;
	assign status.last     = last_q;
	assign status.out_free = out_free;
	assign out_valid       = out_valid_q;
	assign min_escape_iter = out_q;

endmodule

[rtl/core/escape_time_min_over_samples_unit.sv]
// From input accept, an item passes through coordinate setup, then the square and
// update loop around the product registers for each escape-time step run (at most
// the iteration cap), then the fold; a stalled earlier result delays the result of
// a batch end further. The unit takes no new item until the last one is folded.
// Reset (arst_n low) clears the sequencer, the output valid and the running
// minimum, and loads the configuration registers with their default view.
// ---------------------------------------------------------------------------
// escape_time_min_over_samples_unit: escape-time minimum over sample batches
// Iterates z = z^2 + c per grid sample and emits the least escape count of
// each batch on its last sample.
// ---------------------------------------------------------------------------
module escape_time_min_over_samples_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [etsm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [etsm_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [etsm_pkg::OFFS_W-1:0]      col_offset,
	input  logic signed [etsm_pkg::OFFS_W-1:0]      row_offset,
	input  logic                                    last_sample,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [etsm_pkg::ITER_BITS-1:0]          min_escape_iter
);
	import etsm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	etsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	etsm_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.col_offset      (col_offset),
		.row_offset      (row_offset),
		.last_sample     (last_sample),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.min_escape_iter (min_escape_iter)
	);

endmodule

[rtl/core/etsm_checker.sv]
// ---------------------------------------------------------------------------
// etsm_checker: port-level checks for the escape-time minimum unit
// Watches the handshakes and result values over time, bound to the top level.
// ---------------------------------------------------------------------------
module etsm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [etsm_pkg::ITER_BITS-1:0]     min_escape_iter
);
	import etsm_pkg::*;

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(min_escape_iter))
		else $error("stalled result changed");

	// Every result is at least one.
	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_escape_iter != '0)
		else $error("result below one");

	// The unit works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// No item finishes in the cycle right after it is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind escape_time_min_over_samples_unit etsm_checker u_etsm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.min_escape_iter (min_escape_iter)
);

[test/escape_time_min_over_samples_checker.sv]
// ---------------------------------------------------------------------------
// escape_time_min_over_samples_checker: prediction and scoreboard
// Watches the register port and both item channels of the escape-time unit,
// predicts the minimum escape count of every batch and compares each result
// item with the oldest predicted minimum.
// ---------------------------------------------------------------------------
module escape_time_min_over_samples_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [etsm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [etsm_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    in_valid,
	input  logic                                    in_stall,
	input  logic signed [etsm_pkg::OFFS_W-1:0]      col_offset,
	input  logic signed [etsm_pkg::OFFS_W-1:0]      row_offset,
	input  logic                                    last_sample,
	input  logic                                    out_valid,
	input  logic                                    out_stall,
	input  logic [etsm_pkg::ITER_BITS-1:0]          min_escape_iter,
	output int                                      pending_results,
	output int                                      mismatch_count,
	output int                                      checked_results
);
	timeunit 1ns;
	timeprecision 1ps;

	import etsm_pkg::*;

	// Shadow copy of the view and the iteration cap.
	logic signed [COORD_W-1:0] view_cx;
	logic signed [COORD_W-1:0] view_cy;
	logic [STEP_W-1:0]         view_sx;
	logic [STEP_W-1:0]         view_sy;
	logic [ITER_BITS-1:0]      iter_cap;

	logic [ITER_BITS-1:0] batch_min;
	logic [ITER_BITS-1:0] batch_minima_q[$];
	int errors = 0;
	int n_checked = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sh0000_0000_8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[COORD_W-1:0];
	endfunction

	// Number of iterations z = z^2 + c, started from z = c, whose new value
	// stays inside the radius-two disc, up to the cap.
	function automatic logic [ITER_BITS-1:0] escape_steps(
		input logic signed [COORD_W-1:0] c_re,
		input logic signed [COORD_W-1:0] c_im,
		input logic [ITER_BITS-1:0] cap
	);
		logic signed [63:0] zr;
		logic signed [63:0] zi;
		logic signed [63:0] sq_diff;
		logic signed [63:0] cross_term;
		logic [63:0] mag;
		int n;
		bit escaped;
		zr = c_re;
		zi = c_im;
		n = 0;
		escaped = 1'b0;
		while (n < cap && !escaped) begin
			sq_diff = zr * zr - zi * zi;
			cross_term = zr * zi;
			zr = clamp_coord((sq_diff >>> FRAC_BITS) + c_re);
			zi = clamp_coord((cross_term >>> (FRAC_BITS - 1)) + c_im);
			// Both squares can reach 2^62, so the sum is taken as unsigned.
			mag = zr * zr + zi * zi;
			if (mag > ESC_LIMIT) begin
				escaped = 1'b1;
			end else begin
				n++;
			end
		end
		return n[ITER_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic signed [63:0] cx_w;
		logic signed [63:0] cy_w;
		logic signed [63:0] col_w;
		logic signed [63:0] row_w;
		logic signed [63:0] sx_w;
		logic signed [63:0] sy_w;
		logic signed [COORD_W-1:0] c_re;
		logic signed [COORD_W-1:0] c_im;
		logic [ITER_BITS-1:0] steps;
		logic [ITER_BITS-1:0] expected;
		if (!arst_n) begin
			view_cx = CENTER_X_RST;
			view_cy = CENTER_Y_RST;
			view_sx = STEP_X_RST;
			view_sy = STEP_Y_RST;
			iter_cap = ITER_CAP_RST;
			batch_min = ITER_ONES;
			batch_minima_q.delete();
			pending_results <= 0;
			mismatch_count <= 0;
			checked_results <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CENTER_X: view_cx = cfg_data;
					REG_CENTER_Y: view_cy = cfg_data;
					REG_STEP_X:   view_sx = cfg_data[STEP_W-1:0];
					REG_STEP_Y:   view_sy = cfg_data[STEP_W-1:0];
					REG_ITER_CAP: iter_cap = cfg_data[ITER_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				cx_w = view_cx;
				cy_w = view_cy;
				col_w = col_offset;
				row_w = row_offset;
				sx_w = {33'd0, view_sx};
				sy_w = {33'd0, view_sy};
				c_re = clamp_coord(cx_w + col_w * sx_w);
				c_im = clamp_coord(cy_w + row_w * sy_w);
				steps = escape_steps(c_re, c_im, iter_cap);
				if (steps < batch_min) begin
					batch_min = steps;
				end
				if (last_sample) begin
					batch_minima_q.push_back((batch_min == '0) ? ITER_BITS'(1) : batch_min);
					batch_min = ITER_ONES;
				end
			end
			if (out_valid && !out_stall) begin
				if (batch_minima_q.size() == 0) begin
					report_mismatch($sformatf("result item %0d with no batch pending",
						min_escape_iter));
				end else begin
					expected = batch_minima_q.pop_front();
					if (min_escape_iter !== expected) begin
						report_mismatch($sformatf("min_escape_iter got %0d expected %0d",
							min_escape_iter, expected));
					end
					n_checked++;
				end
			end
			pending_results <= batch_minima_q.size();
			mismatch_count <= errors;
			checked_results <= n_checked;
		end
	end

endmodule

[test/tb_escape_time_min_over_samples_unit.sv]
// ---------------------------------------------------------------------------
// tb_escape_time_min_over_samples_unit: top level of the unit testbench
// Drives register settings and batches of grid samples into the escape-time
// unit, with random gaps and output stalls, and gives the verdict from the
// checker's mismatch count.
// ---------------------------------------------------------------------------
module tb_escape_time_min_over_samples_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import etsm_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [OFFS_W-1:0] col_offset;
	logic signed [OFFS_W-1:0] row_offset;
	logic last_sample;
	logic out_valid;
	logic out_stall;
	logic [ITER_BITS-1:0] min_escape_iter;

	int pending_results;
	int mismatch_count;
	int checked_results;

	// Shared with the output side; written with nonblocking assignments only.
	int hold_requests;
	logic rx_idling;

	bit tx_idling;
	int cap_now;
	int n_samples = 0;
	int n_settings = 0;

	always #2 clk = ~clk;

	escape_time_min_over_samples_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.col_offset      (col_offset),
		.row_offset      (row_offset),
		.last_sample     (last_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.min_escape_iter (min_escape_iter)
	);

	escape_time_min_over_samples_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.col_offset      (col_offset),
		.row_offset      (row_offset),
		.last_sample     (last_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.min_escape_iter (min_escape_iter),
		.pending_results (pending_results),
		.mismatch_count  (mismatch_count),
		.checked_results (checked_results)
	);

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_escape_time_min_over_samples_unit: FAIL");
		$finish;
	end

	// Result side: short random stalls, and a long hold-off on request.
	initial begin : output_backpressure
		int seen_holds;
		int burst;
		seen_holds = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != seen_holds) begin
				seen_holds = hold_requests;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_idling && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 6);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Leaves the valid high on return so that back-to-back items need no toggle.
	task automatic send_sample(input logic [OFFS_W-1:0] col, input logic [OFFS_W-1:0] row,
			input logic last);
		int gap;
		if (tx_idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		col_offset <= col;
		row_offset <= row;
		last_sample <= last;
		do @(posedge clk); while (in_stall);
		n_samples++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Unused bits of the narrower registers and one unmapped index get noise.
	task automatic set_view(input logic [31:0] cx, input logic [31:0] cy,
			input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
			input logic [ITER_BITS-1:0] cap);
		write_reg(REG_ITER_CAP + CFG_IDX_W'($urandom_range(1, 3)), $urandom());
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_STEP_X, {1'($urandom()), sx});
		write_reg(REG_STEP_Y, {1'($urandom()), sy});
		write_reg(REG_ITER_CAP, {16'($urandom()), cap});
		cfg_we <= 1'b0;
		cap_now = cap;
		n_settings++;
	endtask

	// Mostly a window on the interesting part of the plane; sometimes any view.
	task automatic random_view(input int max_cap);
		logic [31:0] cx;
		logic [31:0] cy;
		logic [STEP_W-1:0] sx;
		logic [STEP_W-1:0] sy;
		if ($urandom_range(0, 4) == 0) begin
			cx = $urandom();
			cy = $urandom();
			sx = STEP_W'($urandom());
			sy = STEP_W'($urandom());
		end else begin
			cx = 32'($urandom_range(0, 671088640)) - 32'd536870912;
			cy = 32'($urandom_range(0, 644245094)) - 32'd322122547;
			sx = STEP_W'($urandom_range(0, 80530636));
			sy = STEP_W'($urandom_range(0, 80530636));
		end
		set_view(cx, cy, sx, sy, ITER_BITS'($urandom_range(1, max_cap)));
	endtask

	task automatic random_batches(input int count);
		int left_in_batch;
		left_in_batch = 0;
		for (int i = 0; i < count; i++) begin
			if (left_in_batch == 0) begin
				left_in_batch = $urandom_range(1, 8);
			end
			left_in_batch--;
			send_sample(OFFS_W'($urandom()), OFFS_W'($urandom()),
				(left_in_batch == 0) || (i == count - 1));
		end
	endtask

	initial begin : stimulus
		int max_cap;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		col_offset <= '0;
		row_offset <= '0;
		last_sample <= 1'b0;
		hold_requests <= 0;
		rx_idling <= 1'b1;
		tx_idling = 1'b1;
		cap_now = ITER_CAP_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Default view: centre -0.25, spacing 0.5, cap 1000.
		send_sample(4'sd0, 4'sd0, 1'b1);
		send_sample(4'sd7, 4'sd7, 1'b0);
		send_sample(-4'sd8, -4'sd8, 1'b0);
		send_sample(4'sd7, -4'sd8, 1'b0);
		send_sample(-4'sd8, 4'sd7, 1'b1);
		send_sample(-4'sd1, 4'sd0, 1'b1);
		send_sample(4'sd1, 4'sd0, 1'b1);
		send_sample(4'sd0, 4'sd1, 1'b0);
		send_sample(-4'sd2, 4'sd0, 1'b0);
		send_sample(4'sd3, 4'sd0, 1'b0);
		send_sample(4'sd0, 4'sd0, 1'b1);
		send_sample(-4'sd4, 4'sd0, 1'b1);
		send_sample(-4'sd3, 4'sd0, 1'b1);
		drain_results();

		// Extreme centres and spacings, where the sample point saturates.
		set_view(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'd0, 16'd1);
		send_sample(-4'sd8, -4'sd8, 1'b0);
		send_sample(4'sd7, 4'sd7, 1'b0);
		send_sample(4'sd0, 4'sd0, 1'b1);
		drain_results();
		set_view(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 16'd1000);
		send_sample(4'sd7, -4'sd8, 1'b1);
		send_sample(-4'sd8, 4'sd7, 1'b1);
		drain_results();

		// A zero cap runs no iteration, so the batch reports one.
		set_view(32'd0, 32'd0, 31'd0, 31'd0, 16'd0);
		send_sample(4'sd0, 4'sd0, 1'b0);
		send_sample(4'sd3, -4'sd2, 1'b1);
		drain_results();

		// The origin never escapes, so this item runs the full cap.
		set_view(32'd0, 32'd0, 31'd0, 31'd0, 16'hFFFF);
		send_sample(4'sd0, 4'sd0, 1'b1);
		drain_results();

		for (int p = 0; p < 12; p++) begin
			max_cap = (p == 3) ? 1000 : ((p % 4 == 1) ? 200 : 48);
			random_view(max_cap);
			random_batches((p == 3) ? 25 : 40);
			drain_results();
			if (p == 5 || p == 9) begin
				// Hold the result side off while every item closes a batch,
				// so that the unit backs up into its input.
				set_view(32'hF800_0000, 32'd0, 31'd53687091, 31'd53687091,
					ITER_BITS'($urandom_range(4, 16)));
				hold_requests <= hold_requests + 1;
				tx_idling = 1'b0;
				for (int i = 0; i < 40; i++) begin
					send_sample(OFFS_W'($urandom()), OFFS_W'($urandom()), 1'b1);
				end
				tx_idling = 1'b1;
				drain_results();
			end
		end

		// Closing stretch at full rate on both sides.
		rx_idling <= 1'b0;
		tx_idling = 1'b0;
		random_view(48);
		random_batches(60);
		drain_results();
		repeat (2 * cap_now + 8) @(posedge clk);

		$display("Sent %0d samples under %0d register settings; %0d batch minima compared.",
			n_samples, n_settings, checked_results);
		$display("Views included saturating centres, zero and full caps, and output hold-offs.");
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("tb_escape_time_min_over_samples_unit: PASS");
		end else begin
			$display("tb_escape_time_min_over_samples_unit: FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/etsm_pkg.sv
rtl/core/etsm_ctrl.sv
rtl/core/etsm_datapath.sv
rtl/core/escape_time_min_over_samples_unit.sv
rtl/core/etsm_checker.sv
test/escape_time_min_over_samples_checker.sv
test/tb_escape_time_min_over_samples_unit.sv
